[rtl/core/btgs_pkg.sv]
// Types, constants and saturating helpers shared by the biterm topic sampler.
package btgs_pkg;

  localparam int CW            = 32;
  localparam int FRAC_W        = 16;
  localparam int QW            = 32;
  localparam int PRIOR_W       = 24;
  localparam int VOCAB_CFG_W   = 13;
  localparam int TOPIC_CFG_W   = 8;
  localparam int WORD_W        = 12;
  localparam int TOPIC_W       = 7;
  localparam int RAND_W        = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 24;
  localparam int RW            = 50;
  localparam int MW            = 49;
  localparam int MA_W          = 32;
  localparam int MB_W          = 33;
  localparam int MP_W          = 65;
  localparam int SW            = 64;
  localparam int DIV_CNT_W     = 5;
  localparam logic [CW-1:0] WORDS_PER_BITERM = 32'd2;

  localparam logic [PRIOR_W-1:0]     ALPHA_RESET  = 24'd655;
  localparam logic [PRIOR_W-1:0]     BETA_RESET   = 24'd3277;
  localparam logic [VOCAB_CFG_W-1:0] VOCAB_RESET  = 13'd4096;
  localparam logic [TOPIC_CFG_W-1:0] TOPICS_RESET = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA,
    CFG_BETA,
    CFG_VOCAB,
    CFG_TOPICS
  } cfg_idx_t;

  typedef enum logic {
    OP_ADD,
    OP_RESAMPLE
  } op_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD_RD,
    S_UPD_W1,
    S_UPD_RD2,
    S_UPD_W2,
    S_W_RD1,
    S_W_RD2,
    S_W_CAP,
    S_DIV_START,
    S_DIV_RUN,
    S_DIV_END,
    S_MUL_P,
    S_MUL_H,
    S_MUL_L,
    S_SUMW,
    S_ACC,
    S_DRAW_H,
    S_DRAW_L,
    S_DRAW_U,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DONE
  } state_t;

  function automatic logic [CW-1:0] sat_add32(input logic [CW-1:0] x,
                                              input logic [CW-1:0] d);
    logic [CW:0] s;
    s = {1'b0, x} + {1'b0, d};
    return s[CW] ? '1 : s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat_sub32(input logic [CW-1:0] x,
                                              input logic [CW-1:0] d);
    return (x < d) ? '0 : x - d;
  endfunction

  function automatic logic [SW-1:0] sat_add64(input logic [SW-1:0] x,
                                              input logic [SW-1:0] d);
    logic [SW:0] s;
    s = {1'b0, x} + {1'b0, d};
    return s[SW] ? '1 : s[SW-1:0];
  endfunction

endpackage

[rtl/core/btgs_if.sv]
// Valid/ready channel interfaces for the biterm word and the result word.
interface btgs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [btgs_pkg::WORD_W-1:0]   first_word;
  logic [btgs_pkg::WORD_W-1:0]   second_word;
  logic [btgs_pkg::TOPIC_W-1:0]  current_topic;
  logic [btgs_pkg::RAND_W-1:0]   random_fraction;

  modport source (output valid, operation, first_word, second_word, current_topic,
                  random_fraction, input ready);
  modport sink (input valid, operation, first_word, second_word, current_topic,
                random_fraction, output ready);
endinterface

interface btgs_out_if;
  logic                          valid;
  logic                          ready;
  logic [btgs_pkg::TOPIC_W-1:0]  new_topic;

  modport source (output valid, new_topic, input ready);
  modport sink (input valid, new_topic, output ready);
endinterface

[rtl/core/btgs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module btgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/biterm_topic_gibbs_sampler_core.sv]
// Biterm topic model collapsed Gibbs sampler core: count tables and one shared divide/multiply unit.
// After reset the block sweeps the topic-word count memory to zero, one entry a cycle,
// and accepts no word meanwhile.
// A resample word weighs each of the K topics in use: each topic needs two 32-step restoring
// divisions and three passes through the single 32x33 multiplier, all on one shared unit,
// and the topic search reads the running totals memory one entry at a time.
// A division whose divisor is zero or whose ratio would saturate goes from its start state straight to its end state.
// One word is processed at a time; the result is held in an output register until taken.
module biterm_topic_gibbs_sampler_core #(
  parameter int MAX_TOPICS     = 128,
  parameter int MAX_VOCABULARY = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  btgs_in_if.sink                            in_ch,
  btgs_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [btgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [btgs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int TW   = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1;
  localparam int VW   = (MAX_VOCABULARY > 1) ? $clog2(MAX_VOCABULARY) : 1;
  localparam int KW   = $clog2(MAX_TOPICS + 1);
  localparam int VW1  = $clog2(MAX_VOCABULARY + 1);
  localparam int AW   = TW + VW;
  localparam int VBW  = VW1 + btgs_pkg::PRIOR_W;
  localparam int CW   = btgs_pkg::CW;
  localparam int RW   = btgs_pkg::RW;
  localparam int MW   = btgs_pkg::MW;
  localparam int SW   = btgs_pkg::SW;
  localparam int FW   = btgs_pkg::FRAC_W;
  localparam int QW   = btgs_pkg::QW;

  btgs_pkg::state_t state_r, state_nxt;

  logic [btgs_pkg::PRIOR_W-1:0]     alpha_r, beta_r;
  logic [btgs_pkg::VOCAB_CFG_W-1:0] vocab_r;
  logic [btgs_pkg::TOPIC_CFG_W-1:0] topics_r;
  logic [KW-1:0]  keff;
  logic [VW1-1:0] veff;
  logic [TW-1:0]  klast;
  logic [VW-1:0]  vlast;

  logic [AW-1:0]  clr_addr_r;
  logic           out_valid_r;
  logic [btgs_pkg::TOPIC_W-1:0] out_topic_r;

  logic           inc_r, second_r;
  logic [VW-1:0]  w1_r, w2_r;
  logic [TW-1:0]  t_r, tk_r, k_r;
  logic [btgs_pkg::RAND_W-1:0] rnd_r;
  logic [VBW-1:0] vb_r;
  logic [RW-1:0]  n1x_r, n2x_r, d_r, rem_r;
  logic [MW-1:0]  m_r;
  logic [QW-1:0]  q_r, r1_r, p_r;
  logic [btgs_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [btgs_pkg::MP_W-1:0] mul_q_r, hi_r;
  logic [SW-1:0]  w_r, total_r, uhi_r, u_r;

  logic [btgs_pkg::MA_W-1:0] mul_a;
  logic [btgs_pkg::MB_W-1:0] mul_b;

  logic           wtc_we, btc_we, wtot_we, run_we;
  logic [AW-1:0]  wtc_waddr, wtc_raddr;
  logic [TW-1:0]  btc_waddr, btc_raddr, run_waddr, run_raddr;
  logic [CW-1:0]  wtc_wdata, btc_wdata, wtot_wdata, wtc_q, btc_q, wtot_q;
  logic [SW-1:0]  run_wdata, run_q;

  logic [CW-1:0]  btc_upd, wtot_upd, wtc_upd;
  logic [RW-1:0]  num_sel, rem_sh;
  logic [SW-1:0]  total_nxt;
  logic           in_acc, out_free;

  btgs_ram #(.WIDTH(CW), .DEPTH(2 ** AW)) u_wtc_ram (
    .clk(clk), .we(wtc_we), .waddr(wtc_waddr), .wdata(wtc_wdata),
    .raddr(wtc_raddr), .rdata(wtc_q)
  );

  btgs_ram #(.WIDTH(CW), .DEPTH(2 ** TW)) u_btc_ram (
    .clk(clk), .we(btc_we), .waddr(btc_waddr), .wdata(btc_wdata),
    .raddr(btc_raddr), .rdata(btc_q)
  );

  btgs_ram #(.WIDTH(CW), .DEPTH(2 ** TW)) u_wtot_ram (
    .clk(clk), .we(wtot_we), .waddr(btc_waddr), .wdata(wtot_wdata),
    .raddr(btc_raddr), .rdata(wtot_q)
  );

  btgs_ram #(.WIDTH(SW), .DEPTH(2 ** TW)) u_run_ram (
    .clk(clk), .we(run_we), .waddr(run_waddr), .wdata(run_wdata),
    .raddr(run_raddr), .rdata(run_q)
  );

  // Effective topic and vocabulary counts
  always_comb begin
    if (topics_r == '0) begin
      keff = KW'(1);
    end else if (32'(topics_r) > MAX_TOPICS) begin
      keff = KW'(MAX_TOPICS);
    end else begin
      keff = KW'(topics_r);
    end
    if (vocab_r == '0) begin
      veff = VW1'(1);
    end else if (32'(vocab_r) > MAX_VOCABULARY) begin
      veff = VW1'(MAX_VOCABULARY);
    end else begin
      veff = VW1'(vocab_r);
    end
    klast = TW'(keff - KW'(1));
    vlast = VW'(veff - VW1'(1));
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready      = (state_r == btgs_pkg::S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.new_topic = out_topic_r;

  assign btc_upd  = inc_r ? btgs_pkg::sat_add32(btc_q, 32'd1)
                          : btgs_pkg::sat_sub32(btc_q, 32'd1);
  assign wtot_upd = inc_r ? btgs_pkg::sat_add32(wtot_q, btgs_pkg::WORDS_PER_BITERM)
                          : btgs_pkg::sat_sub32(wtot_q, btgs_pkg::WORDS_PER_BITERM);
  assign wtc_upd  = inc_r ? btgs_pkg::sat_add32(wtc_q, 32'd1)
                          : btgs_pkg::sat_sub32(wtc_q, 32'd1);
  assign num_sel  = second_r ? n2x_r : n1x_r;
  assign rem_sh   = {rem_r[RW-2:0], 1'b0};
  assign total_nxt = btgs_pkg::sat_add64(total_r, w_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      btgs_pkg::S_CLEAR:     if (clr_addr_r == '1) state_nxt = btgs_pkg::S_IDLE;
      btgs_pkg::S_IDLE:      if (in_acc) state_nxt = btgs_pkg::S_UPD_RD;
      btgs_pkg::S_UPD_RD:    state_nxt = btgs_pkg::S_UPD_W1;
      btgs_pkg::S_UPD_W1:    state_nxt = btgs_pkg::S_UPD_RD2;
      btgs_pkg::S_UPD_RD2:   state_nxt = btgs_pkg::S_UPD_W2;
      btgs_pkg::S_UPD_W2:    state_nxt = inc_r ? btgs_pkg::S_DONE : btgs_pkg::S_W_RD1;
      btgs_pkg::S_W_RD1:     state_nxt = btgs_pkg::S_W_RD2;
      btgs_pkg::S_W_RD2:     state_nxt = btgs_pkg::S_W_CAP;
      btgs_pkg::S_W_CAP:     state_nxt = btgs_pkg::S_DIV_START;
      btgs_pkg::S_DIV_START: begin
        if (d_r == '0 || num_sel >= d_r) begin
          state_nxt = btgs_pkg::S_DIV_END;
        end else begin
          state_nxt = btgs_pkg::S_DIV_RUN;
        end
      end
      btgs_pkg::S_DIV_RUN:   if (cnt_r == '1) state_nxt = btgs_pkg::S_DIV_END;
      btgs_pkg::S_DIV_END:   state_nxt = second_r ? btgs_pkg::S_MUL_P : btgs_pkg::S_DIV_START;
      btgs_pkg::S_MUL_P:     state_nxt = btgs_pkg::S_MUL_H;
      btgs_pkg::S_MUL_H:     state_nxt = btgs_pkg::S_MUL_L;
      btgs_pkg::S_MUL_L:     state_nxt = btgs_pkg::S_SUMW;
      btgs_pkg::S_SUMW:      state_nxt = btgs_pkg::S_ACC;
      btgs_pkg::S_ACC:       state_nxt = (k_r == klast) ? btgs_pkg::S_DRAW_H : btgs_pkg::S_W_RD1;
      btgs_pkg::S_DRAW_H:    state_nxt = (total_r == '0) ? btgs_pkg::S_UPD_RD : btgs_pkg::S_DRAW_L;
      btgs_pkg::S_DRAW_L:    state_nxt = btgs_pkg::S_DRAW_U;
      btgs_pkg::S_DRAW_U:    state_nxt = btgs_pkg::S_SRCH_RD;
      btgs_pkg::S_SRCH_RD:   state_nxt = btgs_pkg::S_SRCH_CMP;
      btgs_pkg::S_SRCH_CMP: begin
        if (u_r < run_q || k_r == klast) begin
          state_nxt = btgs_pkg::S_UPD_RD;
        end else begin
          state_nxt = btgs_pkg::S_SRCH_RD;
        end
      end
      btgs_pkg::S_DONE:      if (out_free) state_nxt = btgs_pkg::S_IDLE;
      default:               state_nxt = btgs_pkg::S_IDLE;
    endcase
  end

  // Memory and multiplier controls
  always_comb begin
    wtc_we     = 1'b0;
    btc_we     = 1'b0;
    wtot_we    = 1'b0;
    run_we     = 1'b0;
    wtc_waddr  = {tk_r, w1_r};
    wtc_raddr  = {tk_r, w1_r};
    wtc_wdata  = wtc_upd;
    btc_waddr  = tk_r;
    btc_raddr  = tk_r;
    btc_wdata  = btc_upd;
    wtot_wdata = wtot_upd;
    run_waddr  = k_r;
    run_raddr  = k_r;
    run_wdata  = total_nxt;
    mul_a      = r1_r;
    mul_b      = {1'b0, q_r};
    unique case (state_r)
      btgs_pkg::S_CLEAR: begin
        wtc_we     = 1'b1;
        btc_we     = 1'b1;
        wtot_we    = 1'b1;
        wtc_waddr  = clr_addr_r;
        wtc_wdata  = '0;
        btc_waddr  = clr_addr_r[TW-1:0];
        btc_wdata  = '0;
        wtot_wdata = '0;
      end
      btgs_pkg::S_UPD_W1: begin
        wtc_we  = 1'b1;
        btc_we  = 1'b1;
        wtot_we = 1'b1;
      end
      btgs_pkg::S_UPD_RD2: wtc_raddr = {tk_r, w2_r};
      btgs_pkg::S_UPD_W2: begin
        wtc_we    = 1'b1;
        wtc_waddr = {tk_r, w2_r};
      end
      btgs_pkg::S_W_RD1: begin
        wtc_raddr = {k_r, w1_r};
        btc_raddr = k_r;
      end
      btgs_pkg::S_W_RD2: wtc_raddr = {k_r, w2_r};
      btgs_pkg::S_MUL_H: begin
        mul_a = mul_q_r[2*QW-1:QW];
        mul_b = m_r[MW-1:FW];
      end
      btgs_pkg::S_MUL_L: begin
        mul_a = p_r;
        mul_b = btgs_pkg::MB_W'(m_r[FW-1:0]);
      end
      btgs_pkg::S_ACC: run_we = 1'b1;
      btgs_pkg::S_DRAW_H: begin
        mul_a = total_r[SW-1:QW];
        mul_b = btgs_pkg::MB_W'(rnd_r);
      end
      btgs_pkg::S_DRAW_L: begin
        mul_a = total_r[QW-1:0];
        mul_b = btgs_pkg::MB_W'(rnd_r);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btgs_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      alpha_r     <= btgs_pkg::ALPHA_RESET;
      beta_r      <= btgs_pkg::BETA_RESET;
      vocab_r     <= btgs_pkg::VOCAB_RESET;
      topics_r    <= btgs_pkg::TOPICS_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == btgs_pkg::S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == btgs_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (btgs_pkg::cfg_idx_t'(cfg_index))
          btgs_pkg::CFG_ALPHA:  alpha_r  <= cfg_data;
          btgs_pkg::CFG_BETA:   beta_r   <= cfg_data;
          btgs_pkg::CFG_VOCAB:  vocab_r  <= cfg_data[btgs_pkg::VOCAB_CFG_W-1:0];
          btgs_pkg::CFG_TOPICS: topics_r <= cfg_data[btgs_pkg::TOPIC_CFG_W-1:0];
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    mul_q_r <= btgs_pkg::MP_W'(mul_a) * btgs_pkg::MP_W'(mul_b);
    case (state_r)
      btgs_pkg::S_IDLE: begin
        if (in_acc) begin
          inc_r <= (btgs_pkg::op_t'(in_ch.operation) == btgs_pkg::OP_ADD);
          w1_r  <= (32'(in_ch.first_word) >= 32'(veff)) ? vlast : VW'(in_ch.first_word);
          w2_r  <= (32'(in_ch.second_word) >= 32'(veff)) ? vlast : VW'(in_ch.second_word);
          t_r   <= (32'(in_ch.current_topic) >= 32'(keff)) ? klast
                                                             : TW'(in_ch.current_topic);
          tk_r  <= (32'(in_ch.current_topic) >= 32'(keff)) ? klast
                                                             : TW'(in_ch.current_topic);
          rnd_r <= in_ch.random_fraction;
          vb_r  <= VBW'(veff) * VBW'(beta_r);
        end
      end
      btgs_pkg::S_UPD_W2: begin
        k_r     <= '0;
        total_r <= '0;
      end
      btgs_pkg::S_W_RD2: begin
        n1x_r <= RW'({wtc_q, {FW{1'b0}}}) + RW'(beta_r);
        m_r   <= MW'({btc_q, {FW{1'b0}}}) + MW'(alpha_r);
        d_r   <= RW'({wtot_q, {FW{1'b0}}}) + RW'(vb_r);
      end
      btgs_pkg::S_W_CAP: begin
        n2x_r    <= RW'({wtc_q, {FW{1'b0}}}) + RW'(beta_r);
        second_r <= 1'b0;
      end
      btgs_pkg::S_DIV_START: begin
        rem_r <= num_sel;
        cnt_r <= '0;
        if (d_r == '0) begin
          q_r <= '0;
        end else if (num_sel >= d_r) begin
          q_r <= '1;
        end else begin
          q_r <= '0;
        end
      end
      btgs_pkg::S_DIV_RUN: begin
        cnt_r <= cnt_r + btgs_pkg::DIV_CNT_W'(1);
        if (rem_sh >= d_r) begin
          rem_r <= rem_sh - d_r;
          q_r   <= {q_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[QW-2:0], 1'b0};
        end
      end
      btgs_pkg::S_DIV_END: begin
        if (!second_r) begin
          r1_r     <= q_r;
          second_r <= 1'b1;
        end
      end
      btgs_pkg::S_MUL_H: p_r  <= mul_q_r[2*QW-1:QW];
      btgs_pkg::S_MUL_L: hi_r <= mul_q_r;
      btgs_pkg::S_SUMW: begin
        w_r <= hi_r[btgs_pkg::MP_W-1] ? '1
               : btgs_pkg::sat_add64(hi_r[SW-1:0], SW'(mul_q_r[SW-1:FW]));
      end
      btgs_pkg::S_ACC: begin
        total_r <= total_nxt;
        k_r     <= k_r + TW'(1);
      end
      btgs_pkg::S_DRAW_H: begin
        if (total_r == '0) begin
          tk_r  <= t_r;
          inc_r <= 1'b1;
        end
      end
      btgs_pkg::S_DRAW_L: uhi_r <= mul_q_r[SW-1:0];
      btgs_pkg::S_DRAW_U: begin
        u_r <= uhi_r + SW'(mul_q_r[SW-1:QW]);
        k_r <= '0;
      end
      btgs_pkg::S_SRCH_CMP: begin
        if (u_r < run_q || k_r == klast) begin
          tk_r  <= k_r;
          inc_r <= 1'b1;
        end else begin
          k_r <= k_r + TW'(1);
        end
      end
      btgs_pkg::S_DONE: begin
        if (out_free) begin
          out_topic_r <= btgs_pkg::TOPIC_W'(tk_r);
        end
      end
      default: begin
      end
    endcase
  end

  a_topic_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(out_topic_r) < 32'(keff)))
    else $error("result topic beyond topics in use");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == btgs_pkg::S_ACC) |=> (total_r >= $past(total_r)))
    else $error("running weight total decreased");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == btgs_pkg::S_DIV_RUN) |-> (rem_r < d_r))
    else $error("divider remainder not below divisor");

endmodule
